>>> rtl/utp_hep_pkg.sv
package utp_hep_pkg;

  localparam int HDR_BYTES = 20;
  localparam int HDR_BITS  = HDR_BYTES * 8;

  localparam logic [1:0] KIND_EXT_START = 2'd0;
  localparam logic [1:0] KIND_EXT_BYTE  = 2'd1;
  localparam logic [1:0] KIND_SUMMARY   = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SHORT     = 2'd1;
  localparam logic [1:0] STATUS_BAD_VER   = 2'd2;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

  localparam logic [3:0] VERSION_RESET = 4'd1;
  localparam logic [3:0] NIBBLE_MASK   = 4'hF;

  // one queue entry: what a single input byte produced
  typedef struct packed {
    logic                has_ext;
    logic                ext_is_byte;
    logic [7:0]          ext_type;
    logic [7:0]          ext_byte;
    logic                has_sum;
    logic [1:0]          status;
    logic [HDR_BITS-1:0] hdr;
  } utp_hep_entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [3:0]  packet_type;
    logic [7:0]  first_extension;
    logic [15:0] connection_id;
    logic [31:0] send_time;
    logic [31:0] time_difference;
    logic [31:0] window_size;
    logic [15:0] sequence_number;
    logic [15:0] acknowledge_number;
    logic [7:0]  ext_type;
    logic [7:0]  ext_byte;
  } utp_hep_result_t;

endpackage

>>> rtl/utp_hep_if.sv
interface utp_hep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       final_byte;

  modport source (output valid, output byte_value, output final_byte, input ready);
  modport sink   (input valid, input byte_value, input final_byte, output ready);
endinterface

interface utp_hep_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic [3:0]  packet_type;
  logic [7:0]  first_extension;
  logic [15:0] connection_id;
  logic [31:0] send_time;
  logic [31:0] time_difference;
  logic [31:0] window_size;
  logic [15:0] sequence_number;
  logic [15:0] acknowledge_number;
  logic [7:0]  ext_type;
  logic [7:0]  ext_byte;

  modport source (
    output valid, output kind, output status, output packet_type, output first_extension,
    output connection_id, output send_time, output time_difference, output window_size,
    output sequence_number, output acknowledge_number, output ext_type, output ext_byte,
    input ready
  );
  modport sink (
    input valid, input kind, input status, input packet_type, input first_extension,
    input connection_id, input send_time, input time_difference, input window_size,
    input sequence_number, input acknowledge_number, input ext_type, input ext_byte,
    output ready
  );
endinterface

>>> rtl/utp_header_extension_parser_top.sv
// Each result is written into the queue and then registered in the output stage before it is sent.
// Throughput: one byte per cycle while the queue is not full; a final byte that also yields an extension result
//   gives two results, sent one after the other, and may stall the input.
// The output stage issues at most one result per cycle; the queue decouples parser and output.
// Reset: synchronous, active low; clears parser, queue and output stage,
//   and sets expected_version to 1.
module utp_header_extension_parser_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  utp_hep_in_if.sink   in_ch,
  utp_hep_out_if.source out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import utp_hep_pkg::*;

  logic            ver_sel;
  logic [3:0]      ver_r;
  logic            accept;
  logic            push, pop, q_full, q_valid;
  utp_hep_entry_t  push_entry, head;
  utp_hep_result_t res;

  assign pready  = 1'b1;
  assign ver_sel = !paddr[2];
  assign prdata  = ver_sel ? {28'd0, ver_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_r <= VERSION_RESET;
    end else if (psel && penable && pwrite && ver_sel) begin
      ver_r <= pwdata[3:0] & NIBBLE_MASK;
    end
  end

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  utp_hep_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .byte_value       (in_ch.byte_value),
    .final_byte       (in_ch.final_byte),
    .expected_version (ver_r),
    .push             (push),
    .push_entry       (push_entry)
  );

  utp_hep_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head       (head)
  );

  utp_hep_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_res    (res)
  );

  assign out_ch.kind               = res.kind;
  assign out_ch.status             = res.status;
  assign out_ch.packet_type        = res.packet_type;
  assign out_ch.first_extension    = res.first_extension;
  assign out_ch.connection_id      = res.connection_id;
  assign out_ch.send_time          = res.send_time;
  assign out_ch.time_difference    = res.time_difference;
  assign out_ch.window_size        = res.window_size;
  assign out_ch.sequence_number    = res.sequence_number;
  assign out_ch.acknowledge_number = res.acknowledge_number;
  assign out_ch.ext_type           = res.ext_type;
  assign out_ch.ext_byte           = res.ext_byte;

endmodule

>>> rtl/utp_hep_front.sv
module utp_hep_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [7:0]                 byte_value,
  input  logic                       final_byte,
  input  logic [3:0]                 expected_version,
  output logic                       push,
  output utp_hep_pkg::utp_hep_entry_t push_entry
);
  import utp_hep_pkg::*;

  typedef enum logic [1:0] {
    PH_TYPE    = 2'd0,
    PH_LEN     = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  localparam logic [4:0] POS_FULL = 5'(HDR_BYTES);
  localparam logic [4:0] POS_LAST = 5'(HDR_BYTES - 1);

  phase_t              phase_r, phase_nxt;
  logic [4:0]          pos_r, pos_nxt;
  logic [HDR_BITS-1:0] hdr_r, hdr_nxt;
  logic                vbad_r, vbad_nxt;
  logic [7:0]          cur_r, cur_nxt;
  logic [7:0]          fol_r, fol_nxt;
  logic [7:0]          left_r, left_nxt;
  logic                ext_v;
  logic                ext_is_byte;

  always_comb begin
    pos_nxt     = pos_r;
    hdr_nxt     = hdr_r;
    vbad_nxt    = vbad_r;
    phase_nxt   = phase_r;
    cur_nxt     = cur_r;
    fol_nxt     = fol_r;
    left_nxt    = left_r;
    ext_v       = 1'b0;
    ext_is_byte = 1'b0;

    if (pos_r != POS_FULL) begin
      if (pos_r == 5'd0) begin
        vbad_nxt = (byte_value[3:0] & NIBBLE_MASK) != expected_version;
      end
      hdr_nxt = {hdr_r[HDR_BITS-9:0], byte_value};
      pos_nxt = pos_r + 5'd1;
      if (pos_r == POS_LAST) begin
        // header byte 1 holds the first extension type
        cur_nxt   = hdr_nxt[HDR_BITS-9 -: 8];
        phase_nxt = (vbad_r || cur_nxt == 8'd0) ? PH_DONE : PH_TYPE;
      end
    end else begin
      unique case (phase_r)
        PH_TYPE: begin
          fol_nxt   = byte_value;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          ext_v    = 1'b1;
          left_nxt = byte_value;
          if (byte_value == 8'd0) begin
            cur_nxt   = fol_r;
            phase_nxt = (fol_r == 8'd0) ? PH_DONE : PH_TYPE;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          ext_v       = 1'b1;
          ext_is_byte = 1'b1;
          left_nxt    = left_r - 8'd1;
          if (left_nxt == 8'd0) begin
            cur_nxt   = fol_r;
            phase_nxt = (fol_r == 8'd0) ? PH_DONE : PH_TYPE;
          end
        end
        PH_DONE: begin
        end
      endcase
    end

    push_entry.has_ext     = ext_v;
    push_entry.ext_is_byte = ext_is_byte;
    push_entry.ext_type    = cur_r;
    push_entry.ext_byte    = byte_value;
    push_entry.has_sum     = final_byte;
    push_entry.hdr         = hdr_nxt;
    if (pos_nxt != POS_FULL) begin
      push_entry.status = STATUS_SHORT;
      push_entry.hdr    = '0;
    end else if (vbad_nxt) begin
      push_entry.status = STATUS_BAD_VER;
    end else if (phase_nxt != PH_DONE) begin
      push_entry.status = STATUS_TRUNCATED;
    end else begin
      push_entry.status = STATUS_OK;
    end

    push = accept && (ext_v || final_byte);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      pos_r   <= '0;
      hdr_r   <= '0;
      vbad_r  <= 1'b0;
      cur_r   <= '0;
      fol_r   <= '0;
      left_r  <= '0;
    end else if (accept) begin
      if (final_byte) begin
        phase_r <= PH_TYPE;
        pos_r   <= '0;
        hdr_r   <= '0;
        vbad_r  <= 1'b0;
        cur_r   <= '0;
        fol_r   <= '0;
        left_r  <= '0;
      end else begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        hdr_r   <= hdr_nxt;
        vbad_r  <= vbad_nxt;
        cur_r   <= cur_nxt;
        fol_r   <= fol_nxt;
        left_r  <= left_nxt;
      end
    end
  end

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_FULL)
    else $error("header position past header length");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && final_byte |=> pos_r == 5'd0 && phase_r == PH_TYPE)
    else $error("packet state not cleared after final byte");

  a_chain_after_header: assert property (@(posedge clk) disable iff (!rst_n)
    ext_v |-> pos_r == POS_FULL && !vbad_r)
    else $error("extension reported outside a valid chain walk");

endmodule

>>> rtl/utp_hep_queue.sv
module utp_hep_queue #(
  parameter int DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  utp_hep_pkg::utp_hep_entry_t push_entry,
  input  logic                        pop,
  output logic                        full,
  output logic                        head_valid,
  output utp_hep_pkg::utp_hep_entry_t head
);
  import utp_hep_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  utp_hep_entry_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;

  assign full       = count_r == CW'(DEPTH);
  assign head_valid = count_r != '0;
  assign head       = mem_r[rd_ptr_r];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wrap_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= wrap_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from an empty queue");

endmodule

>>> rtl/utp_hep_back.sv
module utp_hep_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  utp_hep_pkg::utp_hep_entry_t  head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output utp_hep_pkg::utp_hep_result_t out_res
);
  import utp_hep_pkg::*;

  logic            out_valid_r;
  utp_hep_result_t out_r, res_nxt;
  logic            sent_ext_r, sent_ext_nxt;
  logic            load;
  logic            emit_ext;

  assign load     = head_valid && (!out_valid_r || out_ready);
  assign emit_ext = head.has_ext && !sent_ext_r;

  always_comb begin
    res_nxt      = '0;
    pop          = 1'b0;
    sent_ext_nxt = sent_ext_r;
    if (emit_ext) begin
      res_nxt.kind     = head.ext_is_byte ? KIND_EXT_BYTE : KIND_EXT_START;
      res_nxt.ext_type = head.ext_type;
      res_nxt.ext_byte = head.ext_byte;
    end else begin
      res_nxt.kind               = KIND_SUMMARY;
      res_nxt.status             = head.status;
      res_nxt.packet_type        = head.hdr[159:156];
      res_nxt.first_extension    = head.hdr[151:144];
      res_nxt.connection_id      = head.hdr[143:128];
      res_nxt.send_time          = head.hdr[127:96];
      res_nxt.time_difference    = head.hdr[95:64];
      res_nxt.window_size        = head.hdr[63:32];
      res_nxt.sequence_number    = head.hdr[31:16];
      res_nxt.acknowledge_number = head.hdr[15:0];
    end
    if (load) begin
      if (emit_ext && head.has_sum) begin
        sent_ext_nxt = 1'b1;
      end else begin
        pop          = 1'b1;
        sent_ext_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sent_ext_r  <= 1'b0;
    end else begin
      sent_ext_r <= sent_ext_nxt;
      if (load)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  a_split_entry: assert property (@(posedge clk) disable iff (!rst_n)
    sent_ext_r |-> head_valid && head.has_ext && head.has_sum)
    else $error("summary pending without its entry at the queue head");

endmodule
